@@ rtl/sip_subject_value_scanner_macros.svh @@
// assertion macros for the subject value scanner
`ifndef SIP_SUBJECT_VALUE_SCANNER_MACROS_SVH
`define SIP_SUBJECT_VALUE_SCANNER_MACROS_SVH

// same-cycle implication, checked out of reset
`define SVS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, checked out of reset
`define SVS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ rtl/sip_svs_pkg.sv @@
// shared types, codes and byte classes of the subject value scanner
`default_nettype none
package sip_svs_pkg;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_TEXT,
    PH_CR,
    PH_LF
  } phase_t;

  typedef enum logic [1:0] {
    ST_SUCCESS,
    ST_NO_DATA,
    ST_DEAD,
    ST_UNHANDLED
  } status_t;

  localparam logic KIND_PART  = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  localparam logic [7:0] CH_HT      = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0a;
  localparam logic [7:0] CH_CR      = 8'h0d;
  localparam logic [7:0] CH_SP      = 8'h20;
  localparam logic [7:0] ASCII_LO   = 8'h21;
  localparam logic [7:0] ASCII_HI   = 8'h7e;
  localparam logic [7:0] UTF8_LO    = 8'h80;
  localparam logic [7:0] UTF8_HI    = 8'hfd;

  localparam int FIFO_AW    = 1;
  localparam int FIFO_DEPTH = 1 << FIFO_AW;

  typedef struct packed {
    logic        kind;
    logic [7:0]  part_index;
    logic [15:0] part_start;
    logic [15:0] part_length;
    status_t     status;
    logic [15:0] subject_start;
    logic [15:0] subject_length;
    logic [15:0] stop_offset;
    logic        final_res;
  } record_t;

  // one or two records caused by one item
  typedef struct packed {
    logic    two;
    record_t rec0;
    record_t rec1;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  function automatic logic is_lws(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_HT) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_text(input logic [7:0] c);
    return ((c >= ASCII_LO) && (c <= ASCII_HI)) || ((c >= UTF8_LO) && (c <= UTF8_HI));
  endfunction

endpackage
`default_nettype wire

@@ rtl/sip_subject_value_scanner.sv @@
// Subject header value scanner, top level
//
// Input channel in_*: one byte of the header value per item, with first,
// last and empty_req flags; accepted when in_valid is high and in_stall low.
// Output channel out_*: part records (kind 0) and final status records
// (kind 1), one per accepted output item; out_final_res marks the last
// record caused by an input item.
// One input item is taken per cycle while in_stall is low. Bytes that
// close nothing give no record; a CR gives one part record, the last byte
// up to two. The front end classes the byte and updates the scan state in
// the accept cycle and writes the records into a two-entry job queue; the
// back end holds one job in its output register and sends one record per
// cycle while out_stall is low. The first record of a job passes the queue
// and the output register before it can be taken. A job with two records
// holds the output until both have left. in_stall rises while the job queue
// is full, which happens only when the receiver holds out_stall or jobs with
// two records come in faster than one record per cycle leaves.
// Reset clears the scan state to skipping leading spaces at offset zero,
// and empties the queue and the output register.
`default_nettype none
module sip_subject_value_scanner import sip_svs_pkg::*; #(
  parameter int OFFSET_BITS     = 16,
  parameter int PART_COUNT_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_text_byte,
  input  wire logic        in_first,
  input  wire logic [15:0] in_base_offset,
  input  wire logic        in_last,
  input  wire logic        in_empty_req,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_kind,
  output logic [7:0]       out_part_index,
  output logic [15:0]      out_part_start,
  output logic [15:0]      out_part_length,
  output logic [1:0]       out_status,
  output logic [15:0]      out_subject_start,
  output logic [15:0]      out_subject_length,
  output logic [15:0]      out_stop_offset,
  output logic             out_final_res
);

`include "sip_subject_value_scanner_macros.svh"

  logic       in_fire, push, pop;
  job_t       wr_job, rd_job;
  fifo_stat_t q_stat;
  record_t    rec;

  assign in_stall = q_stat.full;
  assign in_fire  = in_valid && !in_stall;

  sip_svs_front #(
    .OFFSET_BITS     (OFFSET_BITS),
    .PART_COUNT_BITS (PART_COUNT_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (in_fire),
    .text_byte   (in_text_byte),
    .first       (in_first),
    .base_offset (in_base_offset),
    .last        (in_last),
    .empty_req   (in_empty_req),
    .push        (push),
    .job         (wr_job)
  );

  sip_svs_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .stat   (q_stat)
  );

  sip_svs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_job     (rd_job),
    .q_pop     (pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_rec   (rec)
  );

  assign out_kind           = rec.kind;
  assign out_part_index     = rec.part_index;
  assign out_part_start     = rec.part_start;
  assign out_part_length    = rec.part_length;
  assign out_status         = rec.status;
  assign out_subject_start  = rec.subject_start;
  assign out_subject_length = rec.subject_length;
  assign out_stop_offset    = rec.stop_offset;
  assign out_final_res      = rec.final_res;

  `SVS_ASSERT_NOW(a_no_push_when_full, push, !q_stat.full)
  `SVS_ASSERT_NOW(a_final_kind_ends_item, out_valid && (out_kind == KIND_FINAL), out_final_res)
  `SVS_ASSERT_NOW(a_part_status_zero, out_valid && (out_kind == KIND_PART), out_status == 2'd0)
  `SVS_ASSERT_NEXT(a_empty_req_queued, in_fire && in_empty_req, !q_stat.empty)

endmodule
`default_nettype wire

@@ rtl/sip_svs_front.sv @@
// front end: byte classing, scan state and record building
`default_nettype none
module sip_svs_front import sip_svs_pkg::*; #(
  parameter int OFFSET_BITS     = 16,
  parameter int PART_COUNT_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        fire,
  input  wire logic [7:0]  text_byte,
  input  wire logic        first,
  input  wire logic [15:0] base_offset,
  input  wire logic        last,
  input  wire logic        empty_req,
  output logic             push,
  output job_t             job
);

  localparam logic [OFFSET_BITS-1:0]     OFF_MAX = '1;
  localparam logic [PART_COUNT_BITS-1:0] CNT_MAX = '1;

  phase_t                     phase_r, phase_nxt;
  logic [OFFSET_BITS-1:0]     pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0]     subj_r, subj_nxt;
  logic [OFFSET_BITS-1:0]     porg_r, porg_nxt;
  logic [PART_COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                       halt_r, halt_nxt;

  phase_t                     ph0, nph;
  logic [OFFSET_BITS-1:0]     pos0, base, subj1, porg1, end_pos;
  logic [PART_COUNT_BITS-1:0] cnt0, cnt1, idx;
  logic                       halt0, dead, cr_hit, gen;
  logic [OFFSET_BITS+15:0]    base_w;
  record_t                    r_cr, r_tail, r_succ, r_unh, r_dead, r_nod;

  function automatic logic [15:0] off16(input logic [OFFSET_BITS-1:0] v);
    logic [OFFSET_BITS+15:0] w;
    w = {{16{1'b0}}, v};
    return w[15:0];
  endfunction

  function automatic logic [7:0] idx8(input logic [PART_COUNT_BITS-1:0] v);
    logic [PART_COUNT_BITS+7:0] w;
    w = {{8{1'b0}}, v};
    return w[7:0];
  endfunction

  always_comb begin
    base_w = {{OFFSET_BITS{1'b0}}, base_offset};
    base   = base_w[OFFSET_BITS-1:0];

    ph0   = phase_r;
    pos0  = pos_r;
    cnt0  = cnt_r;
    halt0 = halt_r;
    if (first) begin
      ph0   = PH_LEAD;
      pos0  = base;
      cnt0  = '0;
      halt0 = 1'b0;
    end

    dead = 1'b0;
    nph  = ph0;
    unique case (ph0)
      PH_LEAD: begin
        priority if (is_lws(text_byte)) nph = PH_LEAD;
        else if (is_text(text_byte)) nph = PH_TEXT;
        else dead = 1'b1;
      end
      PH_TEXT: begin
        priority if (text_byte == CH_CR) nph = PH_CR;
        else if (is_text(text_byte) || is_lws(text_byte)) nph = PH_TEXT;
        else dead = 1'b1;
      end
      PH_CR: begin
        if (text_byte == CH_LF) nph = PH_LF;
        else dead = 1'b1;
      end
      PH_LF: begin
        // fold spaces stay in the fold; anything else legal opens a part
        priority if ((text_byte == CH_SP) || (text_byte == CH_HT)) nph = PH_LF;
        else if (is_text(text_byte) || is_lws(text_byte)) nph = PH_TEXT;
        else dead = 1'b1;
      end
      default: dead = 1'b1;
    endcase

    subj1 = subj_r;
    porg1 = porg_r;
    cnt1  = cnt0;
    if (!dead && (nph == PH_TEXT) && (ph0 == PH_LEAD)) begin
      subj1 = pos0;
      porg1 = pos0;
      cnt1  = {{(PART_COUNT_BITS-1){1'b0}}, 1'b1};
    end else if (!dead && (nph == PH_TEXT) && (ph0 == PH_LF)) begin
      porg1 = pos0;
      if (cnt0 != CNT_MAX) cnt1 = cnt0 + 1'b1;
    end
    cr_hit  = !dead && (nph == PH_CR);
    end_pos = (pos0 != OFF_MAX) ? pos0 + 1'b1 : pos0;
    idx     = (cnt1 != '0) ? cnt1 - 1'b1 : '0;

    r_cr             = '0;
    r_cr.kind        = KIND_PART;
    r_cr.part_index  = idx8(idx);
    r_cr.part_start  = off16(porg1);
    r_cr.part_length = off16(pos0 - porg1);
    r_cr.status      = ST_SUCCESS;
    r_cr.final_res   = !last;

    r_tail             = '0;
    r_tail.kind        = KIND_PART;
    r_tail.part_index  = idx8(idx);
    r_tail.part_start  = off16(porg1);
    r_tail.part_length = off16(end_pos - porg1);
    r_tail.status      = ST_SUCCESS;

    r_succ                = '0;
    r_succ.kind           = KIND_FINAL;
    r_succ.status         = ST_SUCCESS;
    r_succ.subject_start  = off16(subj1);
    r_succ.subject_length = off16(end_pos - subj1);
    r_succ.stop_offset    = off16(end_pos);
    r_succ.final_res      = 1'b1;

    r_unh             = '0;
    r_unh.kind        = KIND_FINAL;
    r_unh.status      = ST_UNHANDLED;
    r_unh.stop_offset = off16(end_pos);
    r_unh.final_res   = 1'b1;

    r_dead             = '0;
    r_dead.kind        = KIND_FINAL;
    r_dead.status      = ST_DEAD;
    r_dead.stop_offset = off16(pos0);
    r_dead.final_res   = 1'b1;

    r_nod           = '0;
    r_nod.kind      = KIND_FINAL;
    r_nod.status    = ST_NO_DATA;
    r_nod.final_res = 1'b1;

    gen       = 1'b0;
    job.two   = 1'b0;
    job.rec0  = r_unh;
    job.rec1  = r_unh;
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    subj_nxt  = subj_r;
    porg_nxt  = porg_r;
    cnt_nxt   = cnt_r;
    halt_nxt  = halt_r;

    priority if (empty_req) begin
      // byte and other flags ignored
      gen       = 1'b1;
      job.rec0  = r_nod;
      phase_nxt = PH_LEAD;
      cnt_nxt   = '0;
      halt_nxt  = 1'b1;
    end else if (halt0) begin
      phase_nxt = ph0;
      pos_nxt   = pos0;
      cnt_nxt   = cnt0;
      halt_nxt  = halt0;
    end else if (dead) begin
      gen       = 1'b1;
      job.rec0  = r_dead;
      phase_nxt = ph0;
      pos_nxt   = pos0;
      cnt_nxt   = cnt0;
      halt_nxt  = 1'b1;
    end else begin
      phase_nxt = nph;
      pos_nxt   = end_pos;
      subj_nxt  = subj1;
      porg_nxt  = porg1;
      cnt_nxt   = cnt1;
      halt_nxt  = last;
      priority if (last && (nph == PH_TEXT)) begin
        gen      = 1'b1;
        job.two  = 1'b1;
        job.rec0 = r_tail;
        job.rec1 = r_succ;
      end else if (last && cr_hit) begin
        gen      = 1'b1;
        job.two  = 1'b1;
        job.rec0 = r_cr;
        job.rec1 = r_unh;
      end else if (last) begin
        gen      = 1'b1;
        job.rec0 = r_unh;
      end else if (cr_hit) begin
        gen      = 1'b1;
        job.rec0 = r_cr;
      end else begin
        gen = 1'b0;
      end
    end

    push = fire && gen;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEAD;
      pos_r   <= '0;
      subj_r  <= '0;
      porg_r  <= '0;
      cnt_r   <= '0;
      halt_r  <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      subj_r  <= subj_nxt;
      porg_r  <= porg_nxt;
      cnt_r   <= cnt_nxt;
      halt_r  <= halt_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/sip_svs_fifo.sv @@
// short job queue between front and back end
`default_nettype none
module sip_svs_fifo import sip_svs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t wr_job,
  input  wire logic pop,
  output job_t      rd_job,
  output fifo_stat_t stat
);

  job_t                 mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]     cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  always_comb begin
    stat.empty = (cnt_r == '0);
    stat.full  = (cnt_r == FIFO_DEPTH[FIFO_AW:0]);
    do_push    = push && !stat.full;
    do_pop     = pop && !stat.empty;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
    rd_job     = mem_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr_job;
  end

endmodule
`default_nettype wire

@@ rtl/sip_svs_back.sv @@
// back end: output register that delivers one record per cycle while out_stall is low
`default_nettype none
module sip_svs_back import sip_svs_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire fifo_stat_t q_stat,
  input  wire job_t       q_job,
  output logic      q_pop,
  input  wire logic out_stall,
  output logic      out_valid,
  output record_t   out_rec
);

  job_t job_r;
  logic busy_r, busy_nxt;
  logic sel_r, sel_nxt;
  logic out_fire, last_rec;

  always_comb begin
    out_valid = busy_r;
    out_rec   = sel_r ? job_r.rec1 : job_r.rec0;
    out_fire  = busy_r && !out_stall;
    last_rec  = sel_r || !job_r.two;
    // reload when idle or as soon as the last record of the held job leaves
    q_pop     = !q_stat.empty && (!busy_r || (out_fire && last_rec));
    busy_nxt  = busy_r;
    sel_nxt   = sel_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
      sel_nxt  = 1'b0;
    end else if (out_fire && !last_rec) begin
      sel_nxt = 1'b1;
    end else if (out_fire) begin
      busy_nxt = 1'b0;
      sel_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      sel_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      sel_r  <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) job_r <= q_job;
  end

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
// testbench for the subject header value scanner: byte stimulus, record checks
module tb_top import sip_svs_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] octet_q_t[$];

  class scan_checker;
    phase_t      cur_phase;
    logic [15:0] offset;
    logic [15:0] subj_begin;
    logic [15:0] part_begin;
    logic [7:0]  part_num;
    bit          stopped;
    record_t     awaited_records[$];
    int          errors;
    int          live_items;
    int          parts_matched;
    int          finals_matched;

    function new();
      cur_phase  = PH_LEAD;
      offset     = '0;
      subj_begin = '0;
      part_begin = '0;
      part_num   = '0;
      stopped    = 1'b0;
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == CH_SP || c == CH_HT || c == CH_CR || c == CH_LF;
    endfunction

    function bit is_visible(logic [7:0] c);
      return (c >= 8'h21 && c <= 8'h7e) || (c >= 8'h80 && c <= 8'hfd);
    endfunction

    function logic [7:0] cur_index();
      return (part_num != 0) ? part_num - 8'd1 : 8'd0;
    endfunction

    function void expect_part(logic [15:0] start, logic [15:0] len, logic fin);
      record_t r;
      r = '0;
      r.kind        = KIND_PART;
      r.part_index  = cur_index();
      r.part_start  = start;
      r.part_length = len;
      r.status      = ST_SUCCESS;
      r.final_res   = fin;
      awaited_records.push_back(r);
    endfunction

    function void expect_status(status_t st, logic [15:0] ss, logic [15:0] sl,
                                logic [15:0] stop);
      record_t r;
      r = '0;
      r.kind           = KIND_FINAL;
      r.status         = st;
      r.subject_start  = ss;
      r.subject_length = sl;
      r.stop_offset    = stop;
      r.final_res      = 1'b1;
      awaited_records.push_back(r);
    endfunction

    // works out the records that one accepted byte causes
    function void take_byte(logic [7:0] c, logic first, logic [15:0] base, logic last,
                            logic empty);
      phase_t      nxt;
      bit          dead;
      logic [15:0] end_pos;
      if (empty) begin
        cur_phase = PH_LEAD;
        part_num  = '0;
        stopped   = 1'b1;
        live_items++;
        expect_status(ST_NO_DATA, '0, '0, '0);
        return;
      end
      if (first) begin
        cur_phase = PH_LEAD;
        offset    = base;
        part_num  = '0;
        stopped   = 1'b0;
      end
      if (stopped) return;
      live_items++;
      dead = 1'b0;
      nxt  = cur_phase;
      case (cur_phase)
        PH_LEAD: begin
          if (is_blank(c)) nxt = PH_LEAD;
          else if (is_visible(c)) nxt = PH_TEXT;
          else dead = 1'b1;
        end
        PH_TEXT: begin
          if (c == CH_CR) nxt = PH_CR;
          else if (is_visible(c) || is_blank(c)) nxt = PH_TEXT;
          else dead = 1'b1;
        end
        PH_CR: begin
          if (c == CH_LF) nxt = PH_LF;
          else dead = 1'b1;
        end
        default: begin
          // fold spaces stay in the fold, any other blank is text again
          if (c == CH_SP || c == CH_HT) nxt = PH_LF;
          else if (is_visible(c) || is_blank(c)) nxt = PH_TEXT;
          else dead = 1'b1;
        end
      endcase
      if (dead) begin
        stopped = 1'b1;
        expect_status(ST_DEAD, '0, '0, offset);
        return;
      end
      if (nxt == PH_TEXT && cur_phase == PH_LEAD) begin
        subj_begin = offset;
        part_begin = offset;
        part_num   = 8'd1;
      end else if (nxt == PH_TEXT && cur_phase == PH_LF) begin
        part_begin = offset;
        if (part_num != 8'hff) part_num++;
      end else if (nxt == PH_CR) begin
        expect_part(part_begin, offset - part_begin, !last);
      end
      cur_phase = nxt;
      end_pos = (offset != 16'hffff) ? offset + 16'd1 : offset;
      if (last) begin
        if (cur_phase == PH_TEXT) begin
          expect_part(part_begin, end_pos - part_begin, 1'b0);
          expect_status(ST_SUCCESS, subj_begin, end_pos - subj_begin, end_pos);
        end else begin
          expect_status(ST_UNHANDLED, '0, '0, end_pos);
        end
        stopped = 1'b1;
      end
      offset = end_pos;
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void match_record(record_t got);
      record_t want;
      if (awaited_records.size() == 0) begin
        $error("record arrived with none awaited: kind %0d status %0d", got.kind, got.status);
        errors++;
        return;
      end
      want = awaited_records.pop_front();
      if (want.kind == KIND_PART) parts_matched++;
      else finals_matched++;
      check_field("kind", want.kind, got.kind);
      check_field("part_index", want.part_index, got.part_index);
      check_field("part_start", want.part_start, got.part_start);
      check_field("part_length", want.part_length, got.part_length);
      check_field("status", want.status, got.status);
      check_field("subject_start", want.subject_start, got.subject_start);
      check_field("subject_length", want.subject_length, got.subject_length);
      check_field("stop_offset", want.stop_offset, got.stop_offset);
      check_field("final_res", want.final_res, got.final_res);
    endfunction

    function int outstanding();
      return awaited_records.size();
    endfunction

    function void close_out();
      if (awaited_records.size() != 0) begin
        $error("%0d records never arrived", awaited_records.size());
        errors += awaited_records.size();
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_text_byte = '0;
  logic        in_first = 1'b0;
  logic [15:0] in_base_offset = '0;
  logic        in_last = 1'b0;
  logic        in_empty_req = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_kind;
  logic [7:0]  out_part_index;
  logic [15:0] out_part_start;
  logic [15:0] out_part_length;
  logic [1:0]  out_status;
  logic [15:0] out_subject_start;
  logic [15:0] out_subject_length;
  logic [15:0] out_stop_offset;
  logic        out_final_res;

  bit          steady = 1'b0;
  record_t     seen_rec;
  scan_checker sb = new();

  sip_subject_value_scanner i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_text_byte       (in_text_byte),
    .in_first           (in_first),
    .in_base_offset     (in_base_offset),
    .in_last            (in_last),
    .in_empty_req       (in_empty_req),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_part_index     (out_part_index),
    .out_part_start     (out_part_start),
    .out_part_length    (out_part_length),
    .out_status         (out_status),
    .out_subject_start  (out_subject_start),
    .out_subject_length (out_subject_length),
    .out_stop_offset    (out_stop_offset),
    .out_final_res      (out_final_res)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < 26);
    end
  end

  // values read here are the ones from before the edge
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      sb.take_byte(in_text_byte, in_first, in_base_offset, in_last, in_empty_req);
    end
    if (rst_n && out_valid && !out_stall) begin
      seen_rec.kind           = out_kind;
      seen_rec.part_index     = out_part_index;
      seen_rec.part_start     = out_part_start;
      seen_rec.part_length    = out_part_length;
      seen_rec.status         = status_t'(out_status);
      seen_rec.subject_start  = out_subject_start;
      seen_rec.subject_length = out_subject_length;
      seen_rec.stop_offset    = out_stop_offset;
      seen_rec.final_res      = out_final_res;
      sb.match_record(seen_rec);
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic f, input logic [15:0] base,
                           input logic l, input logic e);
    if (!steady && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 26);
    end
    in_valid       <= 1'b1;
    in_text_byte   <= b;
    in_first       <= f;
    in_base_offset <= base;
    in_last        <= l;
    in_empty_req   <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // base offset is random filler wherever first is low
  task automatic play_value(input octet_q_t v, input logic [15:0] base, input bit with_first,
                            input bit with_last);
    foreach (v[i]) begin
      push_byte(v[i], with_first && i == 0, (with_first && i == 0) ? base : 16'($urandom),
                with_last && i == v.size() - 1, 1'b0);
    end
  endtask

  function automatic logic [7:0] pick_text();
    if ($urandom_range(1)) return 8'($urandom_range(ASCII_LO, ASCII_HI));
    return 8'($urandom_range(UTF8_LO, UTF8_HI));
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(3))
      0: return CH_SP;
      1: return CH_HT;
      2: return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  task automatic play_directed();
    octet_q_t v;
    // no first flag after reset
    v = '{ASCII_LO, ASCII_HI};
    play_value(v, 16'h1234, 1'b0, 1'b1);
    // leading blanks, folds, CR and LF opening parts after a fold, offset saturation
    v = '{CH_SP, CH_HT, CH_CR, CH_LF, UTF8_LO, UTF8_HI, CH_SP, CH_CR, CH_LF, CH_HT,
          CH_CR, ASCII_LO, CH_CR, CH_LF, CH_LF, ASCII_HI};
    play_value(v, 16'hfff5, 1'b1, 1'b1);
    // dead byte that is also the last one, then a byte that is ignored
    v = '{8'hff};
    play_value(v, 16'h0000, 1'b1, 1'b1);
    push_byte(ASCII_LO, 1'b0, 16'hffff, 1'b1, 1'b0);
    v = '{8'h41, 8'hfe, 8'h7f};
    play_value(v, 16'h8000, 1'b1, 1'b0);
    // CR without LF
    v = '{8'h41, CH_CR, 8'h41};
    play_value(v, 16'h00ff, 1'b1, 1'b0);
    // buffer ends in leading blanks, then ends waiting for LF
    v = '{CH_SP};
    play_value(v, 16'h0100, 1'b1, 1'b1);
    v = '{8'h41, CH_CR};
    play_value(v, 16'h7fff, 1'b1, 1'b1);
    // empty request wins over every other flag
    push_byte(8'h00, 1'b1, 16'hffff, 1'b1, 1'b1);
    push_byte(ASCII_LO, 1'b0, 16'h0000, 1'b0, 1'b0);
  endtask

  // a long chain of folded parts
  task automatic play_fold_chain();
    octet_q_t v;
    v.push_back(pick_text());
    repeat (60) begin
      v.push_back(CH_CR);
      v.push_back(CH_LF);
      if ($urandom_range(3) == 0) v.push_back(CH_SP);
      v.push_back($urandom_range(1) ? CH_CR : pick_text());
    end
    play_value(v, 16'($urandom_range(100)), 1'b1, 1'b1);
  endtask

  task automatic play_random_value();
    octet_q_t    v;
    logic [15:0] base;
    int          pick;
    int          n_parts;
    pick = $urandom_range(99);
    case ($urandom_range(9))
      0: base = 16'hffff - 16'($urandom_range(24));
      1: base = 16'($urandom);
      default: base = 16'($urandom_range(2000));
    endcase
    if (pick < 8) begin
      push_byte(8'($urandom), 1'($urandom), 16'($urandom), 1'($urandom), 1'b1);
      if ($urandom_range(1)) push_byte(8'($urandom), 1'b0, 16'($urandom), 1'($urandom), 1'b0);
      return;
    end
    if (pick < 18) begin
      repeat ($urandom_range(1, 6)) v.push_back(8'($urandom));
      play_value(v, base, $urandom_range(3) != 0, $urandom_range(1));
      return;
    end
    repeat ($urandom_range(0, 3)) v.push_back(pick_blank());
    n_parts = $urandom_range(1, 4);
    for (int p = 0; p < n_parts; p++) begin
      if (p > 0) begin
        v.push_back(CH_CR);
        v.push_back(CH_LF);
        repeat ($urandom_range(0, 2)) v.push_back($urandom_range(1) ? CH_SP : CH_HT);
        if ($urandom_range(9) == 0) v.push_back(pick_blank());
      end
      v.push_back(pick_text());
      repeat ($urandom_range(0, 7)) begin
        if ($urandom_range(4) == 0) v.push_back($urandom_range(1) ? CH_SP : CH_LF);
        else v.push_back(pick_text());
      end
    end
    case ($urandom_range(9))
      0: v.push_back(CH_CR);
      1: begin
        v.push_back(CH_CR);
        v.push_back(CH_LF);
      end
      2: begin
        v.push_back(CH_CR);
        v.push_back(CH_LF);
        v.push_back(CH_HT);
      end
      default: ;
    endcase
    // one corrupted byte somewhere in the value
    if (pick < 30) v[$urandom_range(v.size() - 1)] = 8'($urandom);
    play_value(v, base, 1'b1, $urandom_range(19) != 0);
    if ($urandom_range(3) == 0) push_byte(pick_text(), 1'b0, 16'($urandom), 1'b0, 1'b0);
  endtask

  initial begin
    int iter;
    int goal;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    play_directed();
    goal = sb.live_items + 450;
    iter = 0;
    while (sb.live_items < goal) begin
      steady = (iter >= 10 && iter < 16);
      if (iter == 4) begin
        play_fold_chain();
      end else begin
        play_random_value();
      end
      iter++;
    end
    steady = 1'b0;
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    sb.close_out();
    $display("scanned %0d bytes over %0d header values; matched %0d part and %0d status records",
             sb.live_items, iter, sb.parts_matched, sb.finals_matched);
    $display("long fold chains, offsets at top of range, dead and empty cases");
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
